FILE: src/gjk_simplex_step_assert.svh
// Assertion macros shared by the GJK simplex step RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef GJK_SIMPLEX_STEP_ASSERT_SVH
`define GJK_SIMPLEX_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSS_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GSS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gss_pkg.sv
// Shared types, widths and vector helpers for the GJK simplex step block.
// No dependencies.
package gss_pkg;

  localparam int CW        = 18;   // point coordinates and edge vectors
  localparam int BW        = 55;   // exact cross products and directions
  localparam int LIMB      = 27;   // low limb of a wide multiplicand
  localparam int AW        = 28;   // multiplier operand holding one limb
  localparam int PW        = AW + CW;
  localparam int ACCW      = 76;   // dot product of wide and narrow vectors
  localparam int OUT_DIR_W = 24;
  localparam int MAX_PTS   = 4;

  localparam logic [1:0] VERD_CONT = 2'd0;
  localparam logic [1:0] VERD_HIT  = 2'd1;
  localparam logic [1:0] VERD_MISS = 2'd2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [BW-1:0] big_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } svec_t;

  typedef struct packed {
    big_t x;
    big_t y;
    big_t z;
  } bvec_t;

  typedef enum logic {OP_DOT, OP_CROSS} op_kind_t;

  typedef struct packed {
    logic     start;
    op_kind_t kind;
    logic     swap;   // cross(h, g) instead of cross(g, h)
  } mac_cmd_t;

  typedef struct packed {
    logic done;
    logic pos;        // dot product strictly positive
  } mac_rsp_t;

  function automatic coord_t s_pick(svec_t v, logic [1:0] i);
    case (i)
      2'd0: return v.x;
      2'd1: return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic big_t b_pick(bvec_t v, logic [1:0] i);
    case (i)
      2'd0: return v.x;
      2'd1: return v.y;
      default: return v.z;
    endcase
  endfunction

  function automatic svec_t s_sub(svec_t a, svec_t b);
    svec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic svec_t s_neg(svec_t a);
    svec_t r;
    r.x = -a.x;
    r.y = -a.y;
    r.z = -a.z;
    return r;
  endfunction

  function automatic bvec_t s_ext(svec_t a);
    bvec_t r;
    r.x = big_t'(a.x);
    r.y = big_t'(a.y);
    r.z = big_t'(a.z);
    return r;
  endfunction

  function automatic bvec_t b_neg(bvec_t a);
    bvec_t r;
    r.x = -a.x;
    r.y = -a.y;
    r.z = -a.z;
    return r;
  endfunction

endpackage

FILE: src/gss_mac.sv
// Shared multiply-accumulate unit: dot products and cross products of a wide
// vector with a narrow one, one 28x18 product per cycle. Depends on gss_pkg.
`include "gjk_simplex_step_assert.svh"
module gss_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  gss_pkg::mac_cmd_t cmd,
  input  gss_pkg::bvec_t    g,
  input  gss_pkg::svec_t    h,
  output gss_pkg::mac_rsp_t rsp,
  output gss_pkg::bvec_t    res
);
  import gss_pkg::*;

  logic                   busy_r;
  logic [3:0]             step_r;
  op_kind_t               kind_r;
  logic                   swap_r;
  logic                   pv_r;
  logic signed [PW-1:0]   prod_r;
  logic                   hi_r;
  logic                   neg_r;
  logic                   clast_r;
  logic                   last_r;
  logic [1:0]             comp_r;
  logic signed [ACCW-1:0] acc_r;
  bvec_t                  res_r;
  logic                   done_r;
  logic                   pos_r;

  logic [1:0]             comp;
  logic [1:0]             gi;
  logic [1:0]             hidx;
  logic                   limb;
  logic                   neg;
  logic                   clast;
  logic                   last;
  big_t                   gv;
  logic signed [AW-1:0]   a_op;
  coord_t                 b_op;
  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] pext;
  logic signed [ACCW-1:0] sum;

  // Step decode. Cross: step = {comp, term, limb}; dot: step = {comp, limb}.
  always_comb begin
    gi    = 2'd0;
    hidx  = 2'd0;
    comp  = 2'd0;
    neg   = 1'b0;
    clast = 1'b0;
    last  = 1'b0;
    limb  = step_r[0];
    if (kind_r == OP_DOT) begin
      comp = step_r[2:1];
      gi   = comp;
      hidx = comp;
      last = (step_r == 4'd5);
    end else begin
      comp  = step_r[3:2];
      clast = (step_r[1:0] == 2'b11);
      last  = (step_r == 4'd11);
      case (comp)
        2'd0: begin
          gi   = step_r[1] ? 2'd2 : 2'd1;
          hidx = step_r[1] ? 2'd1 : 2'd2;
        end
        2'd1: begin
          gi   = step_r[1] ? 2'd0 : 2'd2;
          hidx = step_r[1] ? 2'd2 : 2'd0;
        end
        default: begin
          gi   = step_r[1] ? 2'd1 : 2'd0;
          hidx = step_r[1] ? 2'd0 : 2'd1;
        end
      endcase
      neg = swap_r ^ step_r[1];
    end
    gv   = b_pick(g, gi);
    a_op = limb ? $signed(gv[BW-1:LIMB]) : $signed({1'b0, gv[LIMB-1:0]});
    b_op = s_pick(h, hidx);
    prod = a_op * b_op;
    pext = ACCW'(prod_r);
    if (hi_r) begin
      pext = pext <<< LIMB;
    end
    sum = neg_r ? acc_r - pext : acc_r + pext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      pv_r   <= busy_r;
      if (cmd.start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= 4'd0;
        kind_r <= cmd.kind;
        swap_r <= cmd.swap;
        acc_r  <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
      if (busy_r) begin
        prod_r  <= prod;
        hi_r    <= limb;
        neg_r   <= neg;
        clast_r <= clast;
        last_r  <= last;
        comp_r  <= comp;
      end
      if (pv_r) begin
        if (clast_r) begin
          acc_r <= '0;
          case (comp_r)
            2'd0: res_r.x <= sum[BW-1:0];
            2'd1: res_r.y <= sum[BW-1:0];
            default: res_r.z <= sum[BW-1:0];
          endcase
        end else begin
          acc_r <= sum;
        end
        if (last_r) begin
          done_r <= 1'b1;
          pos_r  <= (sum > 0);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.pos  = pos_r;
  assign res      = res_r;

  `GSS_ASSERT_IMPL(a_no_restart, clk, rst_n, cmd.start, !busy_r, "start while busy")
  `GSS_ASSERT_IMPL(a_done_drained, clk, rst_n, done_r, !busy_r && !pv_r,
                   "done with products in flight")
  `GSS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r, "done held two cycles")

endmodule

FILE: src/gss_fit.sv
// Direction rescaler: arithmetic-shifts all three components right one bit
// per cycle until each fits DIR_BITS signed bits. Depends on gss_pkg.
module gss_fit #(
  parameter int DIR_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  gss_pkg::bvec_t             d,
  output logic                       done,
  output logic signed [DIR_BITS-1:0] r_x,
  output logic signed [DIR_BITS-1:0] r_y,
  output logic signed [DIR_BITS-1:0] r_z
);
  import gss_pkg::*;

  logic  busy_r;
  logic  done_r;
  bvec_t v_r;
  logic  fit_all;

  function automatic logic fits(big_t x);
    return (&x[BW-1:DIR_BITS-1]) | (~|x[BW-1:DIR_BITS-1]);
  endfunction

  assign fit_all = fits(v_r.x) & fits(v_r.y) & fits(v_r.z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        v_r    <= d;
      end else if (busy_r) begin
        if (fit_all) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          v_r.x <= v_r.x >>> 1;
          v_r.y <= v_r.y >>> 1;
          v_r.z <= v_r.z >>> 1;
        end
      end
    end
  end

  assign done = done_r;
  assign r_x  = v_r.x[DIR_BITS-1:0];
  assign r_y  = v_r.y[DIR_BITS-1:0];
  assign r_z  = v_r.z[DIR_BITS-1:0];

endmodule

FILE: src/gjk_simplex_step.sv
// GJK simplex step: one 3D support point in, one direction/verdict out.
// Depends on gss_pkg, gss_mac, gss_fit and gjk_simplex_step_assert.svh.
//
// Input stream: in_tdata = support x/y/z (16-bit signed each), in_tuser =
// start flag. A start transaction restarts the simplex at that point; a
// later one is tested against the stored search direction and, if it
// passes, pushed into the simplex (line, triangle or tetrahedron case).
// Output stream: one transaction per input, out_tdata = next direction
// x/y/z (24-bit signed each), out_tuser = verdict (continue, hit, miss).
// One item is processed at a time; in_tready is high only while idle.
// Every product goes through one shared 28x18 multiplier, which runs the
// dot tests and cross products one after another; the direction rescaler
// then shifts the new direction right until it fits. A start item skips
// the multiplier and goes straight to the rescaler; a simplex step ends
// after its first dot test on a miss, and a tetrahedron case may fall back
// through the triangle and line cases. in_tready rises with out_tvalid.
// The result sits in an output register; a stalled receiver holds it and
// the block may take the next item meanwhile, but cannot finish that item
// until the register frees up. Reset empties the simplex and zeroes the
// direction; an item without a prior start then answers miss.
`include "gjk_simplex_step_assert.svh"
module gjk_simplex_step #(
  parameter int COORD_BITS = 16,
  parameter int DIR_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // support_x, support_y, support_z
  input  logic [0:0]  in_tuser,   // start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // dir_x, dir_y, dir_z
  output logic [1:0]  out_tuser   // verdict
);
  import gss_pkg::*;

  localparam int CB   = (COORD_BITS > 16) ? 16 : COORD_BITS;
  localparam bit CNEG = (COORD_BITS <= 16);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SDOT,
    ST_TET1, ST_TET1D, ST_TET2, ST_TET2D, ST_TET3, ST_TET3D,
    ST_TRI1, ST_TRI2, ST_TRI3, ST_TRI4, ST_TRI5, ST_TRI6, ST_TRI7,
    ST_LN1, ST_LN3, ST_LN4, ST_FIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {G_N, G_T, G_DIR, G_AB, G_AC, G_AD} gsel_t;
  typedef enum logic [2:0] {H_AB, H_AC, H_AD, H_AO, H_S} hsel_t;

  state_t                     state_r;
  logic                       issued_r;
  logic [2:0]                 cnt_r;
  svec_t                      s_r;
  svec_t                      p0_r;
  svec_t                      p1_r;
  svec_t                      p2_r;
  svec_t                      p3_r;
  bvec_t                      n_r;
  bvec_t                      t_r;
  bvec_t                      r_r;
  logic signed [DIR_BITS-1:0] dir_x_r;
  logic signed [DIR_BITS-1:0] dir_y_r;
  logic signed [DIR_BITS-1:0] dir_z_r;
  logic [1:0]                 verd_r;
  logic                       out_valid_r;
  logic [71:0]                out_data_r;
  logic [1:0]                 out_user_r;

  svec_t                      s_in;
  svec_t                      ab;
  svec_t                      ac;
  svec_t                      ad;
  svec_t                      ao;
  logic [2:0]                 cnt_n;
  op_kind_t                   kind;
  gsel_t                      gsel;
  hsel_t                      hsel;
  logic                       swap;
  logic                       use_mac;
  bvec_t                      g_vec;
  svec_t                      h_vec;
  mac_cmd_t                   cmd;
  mac_rsp_t                   rsp;
  bvec_t                      res;
  logic                       fit_done;
  logic signed [DIR_BITS-1:0] fr_x;
  logic signed [DIR_BITS-1:0] fr_y;
  logic signed [DIR_BITS-1:0] fr_z;

  function automatic coord_t to_coord(logic [15:0] raw);
    if (CNEG) begin
      return coord_t'($signed(raw[CB-1:0]));
    end
    return coord_t'($signed({1'b0, raw}));
  endfunction

  assign s_in.x = to_coord(in_tdata[15:0]);
  assign s_in.y = to_coord(in_tdata[31:16]);
  assign s_in.z = to_coord(in_tdata[47:32]);

  assign ab    = s_sub(p1_r, p0_r);
  assign ac    = s_sub(p2_r, p0_r);
  assign ad    = s_sub(p3_r, p0_r);
  assign ao    = s_neg(p0_r);
  assign cnt_n = (cnt_r < 3'(MAX_PTS)) ? cnt_r + 3'd1 : 3'(MAX_PTS);

  // Operation issued to the shared unit in each sequencer state.
  always_comb begin
    kind    = OP_DOT;
    gsel    = G_N;
    hsel    = H_AO;
    swap    = 1'b0;
    use_mac = 1'b1;
    case (state_r)
      ST_SDOT: begin
        gsel = G_DIR;
        hsel = H_S;
      end
      ST_TET1, ST_TRI1: begin
        kind = OP_CROSS;
        gsel = G_AB;
        hsel = H_AC;
      end
      ST_TET2: begin
        kind = OP_CROSS;
        gsel = G_AC;
        hsel = H_AD;
      end
      ST_TET3: begin
        kind = OP_CROSS;
        gsel = G_AD;
        hsel = H_AB;
      end
      ST_TET1D, ST_TET2D, ST_TET3D, ST_TRI7: begin
        gsel = G_N;
      end
      ST_TRI2: begin
        kind = OP_CROSS;
        gsel = G_N;
        hsel = H_AC;
      end
      ST_TRI3, ST_TRI6: begin
        gsel = G_T;
      end
      ST_TRI4: begin
        gsel = G_AC;
      end
      ST_TRI5: begin
        kind = OP_CROSS;
        gsel = G_N;
        hsel = H_AB;
        swap = 1'b1;
      end
      ST_LN1: begin
        gsel = G_AB;
      end
      ST_LN3: begin
        kind = OP_CROSS;
        gsel = G_AB;
      end
      ST_LN4: begin
        kind = OP_CROSS;
        gsel = G_T;
        hsel = H_AB;
      end
      default: use_mac = 1'b0;
    endcase
  end

  always_comb begin
    case (gsel)
      G_T:     g_vec = t_r;
      G_DIR:   g_vec = '{x: big_t'(dir_x_r), y: big_t'(dir_y_r), z: big_t'(dir_z_r)};
      G_AB:    g_vec = s_ext(ab);
      G_AC:    g_vec = s_ext(ac);
      G_AD:    g_vec = s_ext(ad);
      default: g_vec = n_r;
    endcase
    case (hsel)
      H_AB:    h_vec = ab;
      H_AC:    h_vec = ac;
      H_AD:    h_vec = ad;
      H_S:     h_vec = s_r;
      default: h_vec = ao;
    endcase
  end

  assign cmd.start = use_mac && !issued_r;
  assign cmd.kind  = kind;
  assign cmd.swap  = swap;

  gss_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .g     (g_vec),
    .h     (h_vec),
    .rsp   (rsp),
    .res   (res)
  );

  gss_fit #(
    .DIR_BITS (DIR_BITS)
  ) u_fit (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == ST_FIT) && !issued_r),
    .d     (r_r),
    .done  (fit_done),
    .r_x   (fr_x),
    .r_y   (fr_y),
    .r_z   (fr_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      cnt_r       <= '0;
      dir_x_r     <= '0;
      dir_y_r     <= '0;
      dir_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (use_mac || state_r == ST_FIT) begin
        issued_r <= 1'b1;
      end
      if (rsp.done || fit_done) begin
        issued_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            s_r <= s_in;
            if (in_tuser[0]) begin
              p0_r    <= s_in;
              cnt_r   <= 3'd1;
              r_r     <= b_neg(s_ext(s_in));
              verd_r  <= VERD_CONT;
              state_r <= ST_FIT;
            end else begin
              state_r <= ST_SDOT;
            end
          end
        end
        ST_SDOT: begin
          if (rsp.done) begin
            if (!rsp.pos) begin
              verd_r  <= VERD_MISS;
              cnt_r   <= '0;
              dir_x_r <= '0;
              dir_y_r <= '0;
              dir_z_r <= '0;
              state_r <= ST_DONE;
            end else begin
              p0_r   <= s_r;
              p1_r   <= p0_r;
              p2_r   <= p1_r;
              p3_r   <= p2_r;
              cnt_r  <= cnt_n;
              verd_r <= VERD_CONT;
              case (cnt_n)
                3'd2:    state_r <= ST_LN1;
                3'd3:    state_r <= ST_TRI1;
                3'd4:    state_r <= ST_TET1;
                default: state_r <= ST_DONE;  // lone point keeps its direction
              endcase
            end
          end
        end
        ST_TET1: begin
          if (rsp.done) begin
            n_r     <= res;
            state_r <= ST_TET1D;
          end
        end
        ST_TET1D: begin
          if (rsp.done) begin
            state_r <= rsp.pos ? ST_TRI1 : ST_TET2;
          end
        end
        ST_TET2: begin
          if (rsp.done) begin
            n_r     <= res;
            state_r <= ST_TET2D;
          end
        end
        ST_TET2D: begin
          if (rsp.done) begin
            if (rsp.pos) begin
              p1_r    <= p2_r;
              p2_r    <= p3_r;
              state_r <= ST_TRI1;
            end else begin
              state_r <= ST_TET3;
            end
          end
        end
        ST_TET3: begin
          if (rsp.done) begin
            n_r     <= res;
            state_r <= ST_TET3D;
          end
        end
        ST_TET3D: begin
          if (rsp.done) begin
            if (rsp.pos) begin
              p1_r    <= p3_r;
              p2_r    <= p1_r;
              state_r <= ST_TRI1;
            end else begin
              // origin enclosed
              verd_r  <= VERD_HIT;
              cnt_r   <= '0;
              dir_x_r <= '0;
              dir_y_r <= '0;
              dir_z_r <= '0;
              state_r <= ST_DONE;
            end
          end
        end
        ST_TRI1: begin
          if (rsp.done) begin
            n_r     <= res;
            state_r <= ST_TRI2;
          end
        end
        ST_TRI2: begin
          if (rsp.done) begin
            t_r     <= res;
            state_r <= ST_TRI3;
          end
        end
        ST_TRI3: begin
          if (rsp.done) begin
            state_r <= rsp.pos ? ST_TRI4 : ST_TRI5;
          end
        end
        ST_TRI4: begin
          if (rsp.done) begin
            if (rsp.pos) begin
              // keep edge a-c: it becomes a-b for the line direction
              p1_r    <= p2_r;
              cnt_r   <= 3'd2;
              state_r <= ST_LN3;
            end else begin
              state_r <= ST_LN1;
            end
          end
        end
        ST_TRI5: begin
          if (rsp.done) begin
            t_r     <= res;
            state_r <= ST_TRI6;
          end
        end
        ST_TRI6: begin
          if (rsp.done) begin
            state_r <= rsp.pos ? ST_LN1 : ST_TRI7;
          end
        end
        ST_TRI7: begin
          if (rsp.done) begin
            cnt_r <= 3'd3;
            if (rsp.pos) begin
              r_r <= n_r;
            end else begin
              p1_r <= p2_r;
              p2_r <= p1_r;
              r_r  <= b_neg(n_r);
            end
            state_r <= ST_FIT;
          end
        end
        ST_LN1: begin
          if (rsp.done) begin
            if (rsp.pos) begin
              cnt_r   <= 3'd2;
              state_r <= ST_LN3;
            end else begin
              cnt_r   <= 3'd1;
              r_r     <= s_ext(ao);
              state_r <= ST_FIT;
            end
          end
        end
        ST_LN3: begin
          if (rsp.done) begin
            t_r     <= res;
            state_r <= ST_LN4;
          end
        end
        ST_LN4: begin
          if (rsp.done) begin
            r_r     <= res;
            state_r <= ST_FIT;
          end
        end
        ST_FIT: begin
          if (fit_done) begin
            dir_x_r <= fr_x;
            dir_y_r <= fr_y;
            dir_z_r <= fr_z;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {OUT_DIR_W'(dir_z_r), OUT_DIR_W'(dir_y_r), OUT_DIR_W'(dir_x_r)};
            out_user_r  <= verd_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `GSS_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready,
                   "second transaction taken while busy")
  `GSS_ASSERT_IMPL(a_out_src, clk, rst_n, $rose(out_tvalid), $past(state_r == ST_DONE),
                   "result raised outside the done state")
  `GSS_ASSERT_IMPL(a_tet_full, clk, rst_n, state_r == ST_TET1, cnt_r == 3'd4,
                   "tetrahedron case without four points")

endmodule

FILE: sim/gjk_simplex_step_tb.sv
// Self-checking testbench for gjk_simplex_step: GJK queries over random
// point clouds plus noise, checked against an in-bench GJK step predictor.
// Depends on gss_pkg and the gjk_simplex_step RTL.
`timescale 1ns / 1ps
module gjk_simplex_step_tb;
  import gss_pkg::*;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [127:0] s128_t;
  typedef struct {s64_t x, y, z;} v3_t;
  typedef struct {
    v3_t  pts [4];
    int   cnt;
    v3_t  dir;
  } gjk_state_t;
  typedef struct {
    logic        start;
    logic [15:0] x, y, z;
  } support_t;
  typedef struct {
    logic [23:0] dx, dy, dz;
    logic [1:0]  verdict;
  } step_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // support_x, support_y, support_z
  logic [0:0]  in_tuser;   // start_req
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // dir_x, dir_y, dir_z
  logic [1:0]  out_tuser;  // verdict

  gjk_simplex_step u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- GJK step predictor ----------------
  function automatic v3_t vsub(v3_t a, v3_t b);
    v3_t r;
    r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
    return r;
  endfunction

  function automatic v3_t vneg(v3_t a);
    v3_t r;
    r.x = -a.x; r.y = -a.y; r.z = -a.z;
    return r;
  endfunction

  function automatic v3_t vcross(v3_t a, v3_t b);
    v3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // exact sign of a dot product whose terms may exceed 64 bits
  function automatic logic dot_pos(v3_t v, v3_t w);
    s128_t acc;
    acc = s128_t'(v.x) * s128_t'(w.x) + s128_t'(v.y) * s128_t'(w.y)
        + s128_t'(v.z) * s128_t'(w.z);
    return acc > 0;
  endfunction

  function automatic logic fits24(s64_t v);
    return v >= -(s64_t'(1) << 23) && v < (s64_t'(1) << 23);
  endfunction

  // common arithmetic right shift until every component fits 24 bits
  function automatic v3_t rescale(v3_t d);
    v3_t r;
    r = d;
    for (int s = 1; s < 64; s++) begin
      if (fits24(r.x) && fits24(r.y) && fits24(r.z)) break;
      r.x = d.x >>> s; r.y = d.y >>> s; r.z = d.z >>> s;
    end
    return r;
  endfunction

  function automatic void set_pts(inout gjk_state_t st, input v3_t a, v3_t b,
                                  v3_t c, int n);
    st.pts[0] = a; st.pts[1] = b; st.pts[2] = c; st.cnt = n;
  endfunction

  function automatic void do_line(inout gjk_state_t st, input v3_t a, v3_t b,
                                  inout v3_t d);
    v3_t ab, ao;
    ab = vsub(b, a);
    ao = vneg(a);
    if (dot_pos(ab, ao)) begin
      set_pts(st, a, b, b, 2);
      d = vcross(vcross(ab, ao), ab);
    end else begin
      set_pts(st, a, a, a, 1);
      d = ao;
    end
  endfunction

  function automatic void do_tri(inout gjk_state_t st, input v3_t a, v3_t b,
                                 v3_t c, inout v3_t d);
    v3_t ab, ac, ao, abc;
    ab = vsub(b, a);
    ac = vsub(c, a);
    ao = vneg(a);
    abc = vcross(ab, ac);
    if (dot_pos(vcross(abc, ac), ao)) begin
      if (dot_pos(ac, ao)) begin
        set_pts(st, a, c, c, 2);
        d = vcross(vcross(ac, ao), ac);
      end else begin
        do_line(st, a, b, d);
      end
    end else if (dot_pos(vcross(ab, abc), ao)) begin
      do_line(st, a, b, d);
    end else if (dot_pos(abc, ao)) begin
      set_pts(st, a, b, c, 3);
      d = abc;
    end else begin
      set_pts(st, a, c, b, 3);
      d = vneg(abc);
    end
  endfunction

  // returns 1 when the tetrahedron encloses the origin
  function automatic logic do_tetra(inout gjk_state_t st, input v3_t a, v3_t b,
                                    v3_t c, v3_t e, inout v3_t d);
    v3_t ab, ac, ad, ao;
    ab = vsub(b, a);
    ac = vsub(c, a);
    ad = vsub(e, a);
    ao = vneg(a);
    if (dot_pos(vcross(ab, ac), ao)) begin
      do_tri(st, a, b, c, d);
      return 1'b0;
    end
    if (dot_pos(vcross(ac, ad), ao)) begin
      do_tri(st, a, c, e, d);
      return 1'b0;
    end
    if (dot_pos(vcross(ad, ab), ao)) begin
      do_tri(st, a, e, b, d);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void gjk_reset(inout gjk_state_t st);
    v3_t zv;
    zv = '{0, 0, 0};
    for (int i = 0; i < 4; i++) st.pts[i] = zv;
    st.cnt = 0;
    st.dir = zv;
  endfunction

  function automatic step_res_t gjk_step(inout gjk_state_t st, input support_t it);
    v3_t s, nd, zv;
    int n;
    step_res_t r;
    zv = '{0, 0, 0};
    s.x = s64_t'($signed(it.x));
    s.y = s64_t'($signed(it.y));
    s.z = s64_t'($signed(it.z));
    r.verdict = VERD_CONT;
    if (it.start) begin
      st.pts[0] = s;
      st.cnt = 1;
      st.dir = rescale(vneg(s));
    end else if (s.x * st.dir.x + s.y * st.dir.y + s.z * st.dir.z <= 0) begin
      r.verdict = VERD_MISS;
      st.cnt = 0;
      st.dir = zv;
    end else begin
      n = (st.cnt < 4) ? st.cnt + 1 : 4;
      for (int i = n - 1; i > 0; i--) st.pts[i] = st.pts[i-1];
      st.pts[0] = s;
      st.cnt = n;
      nd = st.dir;
      if (n == 2) begin
        do_line(st, st.pts[0], st.pts[1], nd);
        st.dir = rescale(nd);
      end else if (n == 3) begin
        do_tri(st, st.pts[0], st.pts[1], st.pts[2], nd);
        st.dir = rescale(nd);
      end else if (n == 4) begin
        if (do_tetra(st, st.pts[0], st.pts[1], st.pts[2], st.pts[3], nd)) begin
          r.verdict = VERD_HIT;
          st.cnt = 0;
          st.dir = zv;
        end else begin
          st.dir = rescale(nd);
        end
      end
    end
    r.dx = st.dir.x[23:0];
    r.dy = st.dir.y[23:0];
    r.dz = st.dir.z[23:0];
    return r;
  endfunction

  // ---------------- stimulus generation ----------------
  support_t   pending_items[$];
  step_res_t  expected_steps[$];
  gjk_state_t gen_state;     // mirror used only to steer queries
  gjk_state_t pred_state;    // predictor fed by accepted transactions
  v3_t        cloud [8];
  int         n_queries;
  logic       fill_done;

  function automatic logic [15:0] clamp16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void push_item(logic st, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] z);
    support_t it;
    step_res_t dummy;
    it = '{st, x, y, z};
    pending_items.push_back(it);
    dummy = gjk_step(gen_state, it);
  endfunction

  function automatic void push_vertex(logic st, v3_t v);
    push_item(st, v.x[15:0], v.y[15:0], v.z[15:0]);
  endfunction

  // farthest cloud vertex along the mirrored search direction
  function automatic v3_t support_of();
    v3_t best;
    s64_t bd, dd;
    best = cloud[0];
    bd = cloud[0].x * gen_state.dir.x + cloud[0].y * gen_state.dir.y
       + cloud[0].z * gen_state.dir.z;
    for (int i = 1; i < 8; i++) begin
      dd = cloud[i].x * gen_state.dir.x + cloud[i].y * gen_state.dir.y
         + cloud[i].z * gen_state.dir.z;
      if (dd > bd) begin
        bd = dd;
        best = cloud[i];
      end
    end
    return best;
  endfunction

  function automatic void run_query();
    v3_t p;
    push_vertex(1'b1, cloud[$urandom_range(0, 7)]);
    for (int k = 0; k < 16 && gen_state.cnt != 0; k++) begin
      p = support_of();
      push_vertex(1'b0, p);
    end
    n_queries++;
  endfunction

  function automatic void make_cloud();
    int amp, cx, cy, cz;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: amp = 60;
      4, 5, 6:    amp = 2000;
      7, 8:       amp = 12000;
      default:    amp = 32767;
    endcase
    // centered near the origin about half the time so hits are common
    if ($urandom_range(0, 1)) begin
      cx = 0; cy = 0; cz = 0;
    end else begin
      cx = $urandom_range(0, 2 * amp) - amp;
      cy = $urandom_range(0, 2 * amp) - amp;
      cz = $urandom_range(0, 2 * amp) - amp;
    end
    for (int i = 0; i < 8; i++) begin
      cloud[i].x = $signed(clamp16(cx + $urandom_range(0, 2 * amp) - amp));
      cloud[i].y = $signed(clamp16(cy + $urandom_range(0, 2 * amp) - amp));
      cloud[i].z = $signed(clamp16(cz + $urandom_range(0, 2 * amp) - amp));
    end
  endfunction

  initial begin
    fill_done = 1'b0;
    n_queries = 0;
    gjk_reset(gen_state);
    // directed: no start after reset, coordinate extremes, zero direction
    push_item(1'b0, 16'h0000, 16'h0000, 16'h0000);
    push_item(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
    push_item(1'b0, 16'h8000, 16'h8000, 16'h8000);
    push_item(1'b1, 16'h8000, 16'h8000, 16'h8000);
    push_item(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    push_item(1'b0, 16'h8000, 16'h7fff, 16'h0000);
    push_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
    push_item(1'b0, 16'h0005, 16'h0005, 16'h0005);
    push_item(1'b1, 16'h8000, 16'h7fff, 16'h8000);
    push_item(1'b0, 16'h7fff, 16'h8000, 16'h7fff);
    push_item(1'b0, 16'h7fff, 16'h7fff, 16'h8000);
    push_item(1'b0, 16'h8000, 16'h8000, 16'h7fff);
    // box around the origin: query should end in a hit
    for (int i = 0; i < 8; i++) begin
      cloud[i].x = i[0] ? 100 : -100;
      cloud[i].y = i[1] ? 90 : -110;
      cloud[i].z = i[2] ? 120 : -80;
    end
    run_query();
    // random: mostly full queries over random clouds, some noise
    while (pending_items.size() < 1400) begin
      if ($urandom_range(0, 6) == 0) begin
        push_item($urandom_range(0, 3) == 0, 16'($urandom), 16'($urandom),
                  16'($urandom));
      end else begin
        make_cloud();
        run_query();
      end
    end
    fill_done = 1'b1;
  end

  // ---------------- driver ----------------
  int n_sent;
  int send_gap;

  always @(posedge clk) begin : drive_proc
    support_t nxt;
    int g;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      send_gap  <= 0;
    end else begin
      g = send_gap;
      if (in_tvalid && in_tready) begin
        expected_steps.push_back(gjk_step(pred_state,
          '{in_tuser[0], in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]}));
        n_sent++;
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (!in_tvalid || in_tready) begin
        if (g == 0 && fill_done && pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          in_tdata  <= {nxt.z, nxt.y, nxt.x};
          in_tuser  <= nxt.start;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
          if (g > 0) g--;
        end
      end
      send_gap <= g;
    end
  end

  // ---------------- monitor / scoreboard ----------------
  int n_errors, n_results, n_hits, n_misses, n_cont;
  int recv_stall, long_hold;
  logic held_once;

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR: result %0d %s got %0h expected %0h", n_results, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk) begin : mon_proc
    step_res_t exp_r;
    int st, hd;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
      long_hold  <= 0;
      held_once  <= 1'b0;
    end else begin
      st = recv_stall;
      hd = long_hold;
      if (out_tvalid && out_tready) begin
        if (expected_steps.size() == 0) begin
          $display("ERROR: unexpected result transaction");
          n_errors++;
        end else begin
          exp_r = expected_steps.pop_front();
          if (out_tdata[23:0] !== exp_r.dx) report_mismatch("dir_x", out_tdata[23:0], exp_r.dx);
          if (out_tdata[47:24] !== exp_r.dy) report_mismatch("dir_y", out_tdata[47:24], exp_r.dy);
          if (out_tdata[71:48] !== exp_r.dz) report_mismatch("dir_z", out_tdata[71:48], exp_r.dz);
          if (out_tuser !== exp_r.verdict) report_mismatch("verdict", out_tuser, exp_r.verdict);
          case (exp_r.verdict)
            VERD_HIT:  n_hits++;
            VERD_MISS: n_misses++;
            default:   n_cont++;
          endcase
        end
        n_results++;
        st = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        // one long back-pressure window so the input side stalls
        if (!held_once && n_results >= 300) begin
          hd = 400;
          held_once <= 1'b1;
        end
      end else begin
        if (st > 0) st--;
        if (hd > 0) hd--;
      end
      recv_stall <= st;
      long_hold  <= hd;
      out_tready <= (st == 0 && hd == 0);
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------- reset and end of run ----------------
  initial begin
    n_errors = 0; n_results = 0; n_sent = 0;
    n_hits = 0; n_misses = 0; n_cont = 0;
    gjk_reset(pred_state);
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (fill_done);
    while (pending_items.size() > 0 || in_tvalid || expected_steps.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d support points in %0d generated queries, %0d results checked",
             n_sent, n_queries, n_results);
    $display("Verdicts: %0d continue, %0d hit, %0d miss", n_cont, n_hits, n_misses);
    if (n_errors == 0 && expected_steps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
